>>> rtl/sml_pkg.sv
// Shared types and constants for the sorted list merge with duplicate folding.
`timescale 1ns / 1ps

package sml_pkg;

   localparam int LIST_DEPTH = 256;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ID_W       = 32;
   localparam int KEY_W      = 32;
   localparam int IDX_W      = 8;
   localparam int ENTRY_W    = ID_W + KEY_W;

   typedef enum logic [1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_PULL          = 2'd2,
      OP_CLEAR         = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_END  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         id;
   } entry_type;

   typedef struct packed {
      logic append;
      logic advance;
      logic clear;
   } list_ctl_type;

   typedef struct packed {
      logic             have;
      logic             more;
      logic             full;
      logic [CNT_W-1:0] cursor;
   } list_stat_type;

endpackage

>>> rtl/sml_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sml_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sml_list.sv
// One list store: entry RAM, fill count, read cursor and prefetched head entry.
`timescale 1ns / 1ps

module sml_list (
   input  logic                  clock,
   input  logic                  reset,
   input  sml_pkg::list_ctl_type ctl,
   input  sml_pkg::entry_type    wr_entry,
   output sml_pkg::entry_type    head,
   output sml_pkg::list_stat_type stat
);

   import sml_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic             bypass_ff, bypass_in;
   entry_type        byp_data_ff;
   logic [ENTRY_W-1:0] rd_data;
   logic             full;
   logic             wr_en;

   assign full  = (count_ff == CNT_W'(LIST_DEPTH));
   assign wr_en = ctl.append && !full;

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      if (ctl.clear) begin
         count_in  = '0;
         cursor_in = '0;
      end else begin
         if (wr_en) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (ctl.advance) begin
            cursor_in = cursor_ff + CNT_W'(1);
         end
      end
      // write and read of the same slot in one cycle: forward the new entry
      bypass_in = wr_en && (count_ff == cursor_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         bypass_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         bypass_ff <= bypass_in;
      end
      byp_data_ff <= wr_entry;
   end

   sml_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (cursor_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign head = bypass_ff ? byp_data_ff : entry_type'(rd_data);

   assign stat.have   = (cursor_ff < count_ff);
   assign stat.more   = ((cursor_ff + CNT_W'(1)) < count_ff);
   assign stat.full   = full;
   assign stat.cursor = cursor_ff;

endmodule

>>> rtl/sorted_list_merge_dedup_top.sv
// Usage notes:
// Merges two id-sorted lists into one ascending list, folding equal ids.
// Request channel (req_valid/req_stall) carries op, entry_id and entry_key:
// append to the first or second list, pull the next merged entry, or clear.
// Every transaction yields exactly one response transaction on the rsp_
// channel with the merged entry (pulls), a full flag (dropped appends) or an
// end flag (pulls past the end); clears and other appends return ST_OK.
// rsp_valid is registered and rises in the cycle after a request is accepted.
// Throughput: one transaction per cycle while req_stall is low, set by the
// head-compare and cursor update against the prefetched list heads; each
// list RAM is read each cycle at its next cursor, written at its fill count.
// Reset clears counts, cursors and rsp_valid; list contents are left as is.
// A stalled response holds its payload; while it is held, req_stall is high,
// and a request is taken in the same cycle the pending response is taken.
`timescale 1ns / 1ps

module sorted_list_merge_dedup_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [sml_pkg::ID_W-1:0]     req_entry_id,
   input  logic signed [sml_pkg::KEY_W-1:0] req_entry_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_out_valid,
   output logic [sml_pkg::ID_W-1:0]     rsp_out_id,
   output logic signed [sml_pkg::KEY_W-1:0] rsp_out_key,
   output logic                         rsp_from_second,
   output logic [sml_pkg::IDX_W-1:0]    rsp_source_index,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_status
);

   import sml_pkg::*;

   list_ctl_type  f_ctl, s_ctl;
   list_stat_type f_st, s_st;
   entry_type     f_head, s_head, wr_entry;
   logic          accept;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic [ID_W-1:0]    out_id_ff, out_id_in;
   logic signed [KEY_W-1:0] out_key_ff, out_key_in;
   logic               from_second_ff, from_second_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               last_ff, last_in;
   status_type         status_ff, status_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign wr_entry.id  = req_entry_id;
   assign wr_entry.key = req_entry_key;

   always_comb begin
      logic      sel_second;
      entry_type sel;
      f_ctl          = '0;
      s_ctl          = '0;
      sel_second     = 1'b0;
      sel            = '0;
      out_valid_in   = 1'b0;
      out_id_in      = '0;
      out_key_in     = '0;
      from_second_in = 1'b0;
      idx_in         = '0;
      last_in        = 1'b0;
      status_in      = ST_OK;
      if (accept) begin
         unique case (op_type'(req_op))
            OP_APPEND_FIRST: begin
               f_ctl.append = 1'b1;
               if (f_st.full) status_in = ST_FULL;
            end
            OP_APPEND_SECOND: begin
               s_ctl.append = 1'b1;
               if (s_st.full) status_in = ST_FULL;
            end
            OP_CLEAR: begin
               f_ctl.clear = 1'b1;
               s_ctl.clear = 1'b1;
            end
            OP_PULL: begin
               if (!f_st.have && !s_st.have) begin
                  status_in = ST_END;
               end else begin
                  if (f_st.have && s_st.have) begin
                     if (f_head.id < s_head.id) begin
                        f_ctl.advance = 1'b1;
                     end else if (f_head.id > s_head.id) begin
                        s_ctl.advance = 1'b1;
                        sel_second    = 1'b1;
                     end else begin
                        f_ctl.advance = 1'b1;
                        s_ctl.advance = 1'b1;
                        sel_second    = !(f_head.key > s_head.key);
                     end
                  end else if (f_st.have) begin
                     f_ctl.advance = 1'b1;
                  end else begin
                     s_ctl.advance = 1'b1;
                     sel_second    = 1'b1;
                  end
                  sel            = sel_second ? s_head : f_head;
                  out_valid_in   = 1'b1;
                  out_id_in      = sel.id;
                  out_key_in     = sel.key;
                  from_second_in = sel_second;
                  idx_in         = sel_second ? IDX_W'(s_st.cursor) : IDX_W'(f_st.cursor);
                  last_in        = !(f_ctl.advance ? f_st.more : f_st.have) &&
                                   !(s_ctl.advance ? s_st.more : s_st.have);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   sml_list u_first (
      .clock    (clock),
      .reset    (reset),
      .ctl      (f_ctl),
      .wr_entry (wr_entry),
      .head     (f_head),
      .stat     (f_st)
   );

   sml_list u_second (
      .clock    (clock),
      .reset    (reset),
      .ctl      (s_ctl),
      .wr_entry (wr_entry),
      .head     (s_head),
      .stat     (s_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         out_valid_ff   <= out_valid_in;
         out_id_ff      <= out_id_in;
         out_key_ff     <= out_key_in;
         from_second_ff <= from_second_in;
         idx_ff         <= idx_in;
         last_ff        <= last_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_key      = out_key_ff;
   assign rsp_from_second  = from_second_ff;
   assign rsp_source_index = idx_ff;
   assign rsp_last         = last_ff;
   assign rsp_status       = status_ff;

endmodule

>>> rtl/sml_checker.sv
// Port-level assertions for the merge block, bound to the top level.
`timescale 1ns / 1ps

module sml_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_op,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_out_valid,
   input logic [sml_pkg::ID_W-1:0]     rsp_out_id,
   input logic signed [sml_pkg::KEY_W-1:0] rsp_out_key,
   input logic                         rsp_from_second,
   input logic [sml_pkg::IDX_W-1:0]    rsp_source_index,
   input logic                         rsp_last,
   input logic [1:0]                   rsp_status
);

   import sml_pkg::*;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_pull_rsp_valid: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == OP_PULL) |=>
      (rsp_out_valid || rsp_status == ST_END))
      else $error("pull gave neither an entry nor an end flag");

   a_append_no_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op != OP_PULL) |=>
      (!rsp_out_valid && rsp_status != ST_END))
      else $error("non-pull request returned a merged entry");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |->
      (rsp_out_id == '0 && rsp_out_key == '0 && !rsp_last && !rsp_from_second &&
       rsp_source_index == '0))
      else $error("response without entry carries nonzero fields");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_id) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind sorted_list_merge_dedup_top sml_checker u_sml_checker (.*);
